// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

  localparam int WIN_DEPTH = 8;
  localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;

  localparam int SEQ_W  = 32;
  localparam int CHAN_W = 8;
  localparam int LEN_W  = 16;
  localparam int HND_W  = 8;
  localparam int FILL_W = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    REQ_ENQUEUE,
    REQ_TX_SLOT,
    REQ_REPLY,
    REQ_TIMEOUT
  } req_t;

  typedef enum logic [2:0] {
    RK_ACCEPTED,
    RK_FULL,
    RK_TRANSMIT,
    RK_IDLE,
    RK_RETIRED,
    RK_REPLY_IGNORED,
    RK_REWOUND,
    RK_TMO_IGNORED
  } kind_t;

  // controller -> datapath
  typedef struct packed {
    logic  load;
    logic  wr;
    logic  send;
    logic  retire;
    logic  rewind;
    kind_t kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pending;
    logic head_match;
  } stat_t;

  // ring slot at offset from head; head < depth and off <= depth
  function automatic idx_t slot_at(idx_t head, cnt_t off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(WIN_DEPTH)) begin
      sum = sum - SUM_W'(WIN_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/gbn_ifs.sv =====
`default_nettype none

interface gbn_in_if import gbn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [SEQ_W-1:0]  seq_number;
  logic [CHAN_W-1:0] channel_id;
  logic [LEN_W-1:0]  payload_length;
  logic [HND_W-1:0]  buffer_handle;
  logic              reply_is_ack;

  modport source (output valid, req_type, seq_number, channel_id, payload_length,
                  buffer_handle, reply_is_ack, input ready);
  modport sink   (input valid, req_type, seq_number, channel_id, payload_length,
                  buffer_handle, reply_is_ack, output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        result_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [CHAN_W-1:0] out_channel;
  logic [LEN_W-1:0]  out_length;
  logic [HND_W-1:0]  out_handle;
  logic [FILL_W-1:0] window_fill;
  logic [FILL_W-1:0] unsent_pending;

  modport source (output valid, result_kind, out_seq, out_channel, out_length,
                  out_handle, window_fill, unsent_pending, input ready);
  modport sink   (input valid, result_kind, out_seq, out_channel, out_length,
                  out_handle, window_fill, unsent_pending, output ready);
endinterface

`default_nettype wire

// ===== design/go_back_n_send_window.sv =====
// Result: each transferred request is registered in the result register.
// Throughput: one request per cycle while out_ready holds; the result register
// frees in the cycle it is taken, so a new request is accepted as it drains.
// Reset: synchronous, active-low rst_n clears head, fill and sent counters and
// empties the result register; descriptor storage is not cleared.
`default_nettype none

module go_back_n_send_window import gbn_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  gbn_in_if.sink   in_chan,
  gbn_out_if.source out_chan
);

  // Controller decodes each request against window status and issues one
  // command set per transfer; the datapath owns the descriptor ring, the
  // head/fill/sent counters and the result register.
  cmd_t  cmd;
  stat_t stat;

  gbn_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .req_type     (in_chan.req_type),
    .reply_is_ack (in_chan.reply_is_ack),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Ring read is a single port: reply requests look at the head entry,
  // transmit slots at the first unsent entry. Retire saturates the sent
  // count at zero; timeout rewinds it so every held entry is resent.
  gbn_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (in_chan.req_type),
    .seq_number     (in_chan.seq_number),
    .channel_id     (in_chan.channel_id),
    .payload_length (in_chan.payload_length),
    .buffer_handle  (in_chan.buffer_handle),
    .result_kind    (out_chan.result_kind),
    .out_seq        (out_chan.out_seq),
    .out_channel    (out_chan.out_channel),
    .out_length     (out_chan.out_length),
    .out_handle     (out_chan.out_handle),
    .window_fill    (out_chan.window_fill),
    .unsent_pending (out_chan.unsent_pending)
  );

endmodule

`default_nettype wire

// ===== design/gbn_datapath.sv =====
`default_nettype none

module gbn_datapath import gbn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output      stat_t             stat,
  input  wire logic [1:0]        req_type,
  input  wire logic [SEQ_W-1:0]  seq_number,
  input  wire logic [CHAN_W-1:0] channel_id,
  input  wire logic [LEN_W-1:0]  payload_length,
  input  wire logic [HND_W-1:0]  buffer_handle,
  output      logic [2:0]        result_kind,
  output      logic [SEQ_W-1:0]  out_seq,
  output      logic [CHAN_W-1:0] out_channel,
  output      logic [LEN_W-1:0]  out_length,
  output      logic [HND_W-1:0]  out_handle,
  output      logic [FILL_W-1:0] window_fill,
  output      logic [FILL_W-1:0] unsent_pending
);

  `include "assert_macros.svh"

  // descriptor ring, no reset
  logic [SEQ_W-1:0]  ent_seq_r  [WIN_DEPTH];
  logic [CHAN_W-1:0] ent_chan_r [WIN_DEPTH];
  logic [LEN_W-1:0]  ent_len_r  [WIN_DEPTH];
  logic [HND_W-1:0]  ent_hnd_r  [WIN_DEPTH];

  idx_t head_r, head_nxt;
  cnt_t fill_r, fill_nxt;
  cnt_t sent_r, sent_nxt;

  logic [2:0]        kind_r;
  logic [SEQ_W-1:0]  oseq_r;
  logic [CHAN_W-1:0] ochan_r;
  logic [LEN_W-1:0]  olen_r;
  logic [HND_W-1:0]  ohnd_r;
  logic [FILL_W-1:0] ofill_r;
  logic [FILL_W-1:0] ounsent_r;

  idx_t wr_idx;
  idx_t rd_idx;
  logic [SEQ_W-1:0]  rd_seq;
  logic [CHAN_W-1:0] rd_chan;
  logic [LEN_W-1:0]  rd_len;
  logic [HND_W-1:0]  rd_hnd;
  logic              show_seq;
  logic              show_desc;

  assign wr_idx = slot_at(head_r, fill_r);
  // one read port: reply looks at head, everything else at next unsent
  assign rd_idx = (req_t'(req_type) == REQ_REPLY) ? head_r : slot_at(head_r, sent_r);

  assign rd_seq  = ent_seq_r[rd_idx];
  assign rd_chan = ent_chan_r[rd_idx];
  assign rd_len  = ent_len_r[rd_idx];
  assign rd_hnd  = ent_hnd_r[rd_idx];

  assign stat.full       = (fill_r == cnt_t'(WIN_DEPTH));
  assign stat.empty      = (fill_r == '0);
  assign stat.pending    = (sent_r < fill_r);
  assign stat.head_match = (rd_seq == seq_number);

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    sent_nxt = sent_r;
    if (cmd.wr) begin
      fill_nxt = fill_r + cnt_t'(1);
    end
    if (cmd.send) begin
      sent_nxt = sent_r + cnt_t'(1);
    end
    if (cmd.retire) begin
      head_nxt = slot_at(head_r, cnt_t'(1));
      fill_nxt = fill_r - cnt_t'(1);
      if (sent_r != '0) begin
        sent_nxt = sent_r - cnt_t'(1);
      end
    end
    if (cmd.rewind) begin
      sent_nxt = '0;
    end
  end

  assign show_seq  = (cmd.kind == RK_TRANSMIT) || (cmd.kind == RK_RETIRED);
  assign show_desc = (cmd.kind == RK_TRANSMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      sent_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      sent_r <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ent_seq_r[wr_idx]  <= seq_number;
      ent_chan_r[wr_idx] <= channel_id;
      ent_len_r[wr_idx]  <= payload_length;
      ent_hnd_r[wr_idx]  <= buffer_handle;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= cmd.kind;
      oseq_r    <= show_seq  ? rd_seq  : '0;
      ochan_r   <= show_desc ? rd_chan : '0;
      olen_r    <= show_desc ? rd_len  : '0;
      ohnd_r    <= show_seq  ? rd_hnd  : '0;
      ofill_r   <= FILL_W'(fill_nxt);
      ounsent_r <= FILL_W'(fill_nxt - sent_nxt);
    end
  end

  assign result_kind    = kind_r;
  assign out_seq        = oseq_r;
  assign out_channel    = ochan_r;
  assign out_length     = olen_r;
  assign out_handle     = ohnd_r;
  assign window_fill    = ofill_r;
  assign unsent_pending = ounsent_r;

  `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r > cnt_t'(WIN_DEPTH), "fill above depth")
  `ASSERT_NEVER(a_sent_bound, clk, rst_n, sent_r > fill_r, "sent count above fill")

endmodule

`default_nettype wire

// ===== design/gbn_ctrl.sv =====
`default_nettype none

module gbn_ctrl import gbn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] req_type,
  input  wire logic       reply_is_ack,
  output      logic       out_valid,
  input  wire logic       out_ready,
  input  wire stat_t      stat,
  output      cmd_t       cmd
);

  `include "assert_macros.svh"

  typedef enum logic {
    S_EMPTY,
    S_HELD
  } state_t;

  state_t state_r, state_nxt;
  logic   fire;

  // result register frees up in the same cycle it is drained
  assign in_ready  = (state_r == S_EMPTY) || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = (state_r == S_HELD);

  always_comb begin
    cmd        = '0;
    cmd.load   = fire;
    cmd.kind   = RK_ACCEPTED;
    unique case (req_t'(req_type))
      REQ_ENQUEUE: begin
        cmd.kind = stat.full ? RK_FULL : RK_ACCEPTED;
        cmd.wr   = fire && !stat.full;
      end
      REQ_TX_SLOT: begin
        cmd.kind = stat.pending ? RK_TRANSMIT : RK_IDLE;
        cmd.send = fire && stat.pending;
      end
      REQ_REPLY: begin
        if (!stat.empty && reply_is_ack && stat.head_match) begin
          cmd.kind   = RK_RETIRED;
          cmd.retire = fire;
        end else begin
          cmd.kind = RK_REPLY_IGNORED;
        end
      end
      REQ_TIMEOUT: begin
        cmd.kind   = stat.empty ? RK_TMO_IGNORED : RK_REWOUND;
        cmd.rewind = fire && !stat.empty;
      end
      default: begin
        cmd.kind = RK_ACCEPTED;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      state_nxt = S_HELD;
    end else if (out_ready) begin
      state_nxt = S_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CHK(a_fire_loads, clk, rst_n, fire |=> out_valid, "accepted request left no result")
  `ASSERT_NEVER(a_wr_full, clk, rst_n, cmd.wr && stat.full, "write into full window")

endmodule

`default_nettype wire

// ===== verif/gbn_window_checker.sv =====
module gbn_window_checker import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gbn_in_if           req_mon,
  gbn_out_if          rsp_mon,
  output int unsigned mismatch_count,
  output int unsigned awaited,
  output int unsigned reqs_seen,
  output int unsigned results_seen,
  output logic [7:0]  kinds_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [CHAN_W-1:0] chan;
    logic [LEN_W-1:0]  len;
    logic [HND_W-1:0]  hnd;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] unsent;
  } window_result_t;

  // predicted window contents and pointers
  logic [SEQ_W-1:0]  slot_seq  [WIN_DEPTH];
  logic [CHAN_W-1:0] slot_chan [WIN_DEPTH];
  logic [LEN_W-1:0]  slot_len  [WIN_DEPTH];
  logic [HND_W-1:0]  slot_hnd  [WIN_DEPTH];
  idx_t head;
  cnt_t fill;
  cnt_t sent;

  window_result_t pending_results[$];
  window_result_t want;

  function automatic idx_t ring_slot(cnt_t off);
    return idx_t'((int'(head) + int'(off)) % WIN_DEPTH);
  endfunction

  function automatic window_result_t window_step(req_t req, logic [SEQ_W-1:0] seq,
                                                 logic [CHAN_W-1:0] chan,
                                                 logic [LEN_W-1:0] len,
                                                 logic [HND_W-1:0] hnd, logic ack);
    window_result_t r;
    idx_t slot;
    r.kind = RK_ACCEPTED;
    r.seq  = '0;
    r.chan = '0;
    r.len  = '0;
    r.hnd  = '0;
    case (req)
      REQ_ENQUEUE: begin
        if (int'(fill) >= WIN_DEPTH) begin
          r.kind = RK_FULL;
        end else begin
          slot = ring_slot(fill);
          slot_seq[slot]  = seq;
          slot_chan[slot] = chan;
          slot_len[slot]  = len;
          slot_hnd[slot]  = hnd;
          fill = fill + 1'b1;
        end
      end
      REQ_TX_SLOT: begin
        if (sent < fill) begin
          slot = ring_slot(sent);
          r.seq  = slot_seq[slot];
          r.chan = slot_chan[slot];
          r.len  = slot_len[slot];
          r.hnd  = slot_hnd[slot];
          sent   = sent + 1'b1;
          r.kind = RK_TRANSMIT;
        end else begin
          r.kind = RK_IDLE;
        end
      end
      REQ_REPLY: begin
        if (fill != 0 && ack && slot_seq[head] == seq) begin
          r.seq  = slot_seq[head];
          r.hnd  = slot_hnd[head];
          head   = idx_t'((int'(head) + 1) % WIN_DEPTH);
          fill   = fill - 1'b1;
          if (sent != 0) sent = sent - 1'b1;  // saturates at zero
          r.kind = RK_RETIRED;
        end else begin
          r.kind = RK_REPLY_IGNORED;
        end
      end
      default: begin
        if (fill != 0) begin
          sent   = '0;
          r.kind = RK_REWOUND;
        end else begin
          r.kind = RK_TMO_IGNORED;
        end
      end
    endcase
    r.fill   = FILL_W'(fill);
    r.unsent = FILL_W'(fill - sent);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head = '0;
      fill = '0;
      sent = '0;
      pending_results.delete();
      mismatch_count = 0;
      reqs_seen      = 0;
      results_seen   = 0;
      kinds_seen     = '0;
      awaited       <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        results_seen++;
        kinds_seen[rsp_mon.result_kind] = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding, kind %0d",
                 rsp_mon.result_kind);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(rsp_mon.result_kind));
          check_field("out_seq", want.seq, rsp_mon.out_seq);
          check_field("out_channel", 32'(want.chan), 32'(rsp_mon.out_channel));
          check_field("out_length", 32'(want.len), 32'(rsp_mon.out_length));
          check_field("out_handle", 32'(want.hnd), 32'(rsp_mon.out_handle));
          check_field("window_fill", 32'(want.fill), 32'(rsp_mon.window_fill));
          check_field("unsent_pending", 32'(want.unsent), 32'(rsp_mon.unsent_pending));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        reqs_seen++;
        pending_results.push_back(window_step(req_t'(req_mon.req_type), req_mon.seq_number,
                                              req_mon.channel_id, req_mon.payload_length,
                                              req_mon.buffer_handle, req_mon.reply_is_ack));
      end
      awaited <= pending_results.size();
    end
  end

endmodule

// ===== verif/go_back_n_send_window_test.sv =====
module go_back_n_send_window_test import gbn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // A full window plus a long result stall stops transfers for a while;
  // anything past this many quiet cycles means the block has hung.
  localparam int STUCK_LIMIT = 5000;
  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n;

  gbn_in_if  in_if ();
  gbn_out_if out_if ();

  int unsigned mismatch_count;
  int unsigned awaited;
  int unsigned reqs_seen;
  int unsigned results_seen;
  logic [7:0]  kinds_seen;

  // idle rates and the enqueue share in percent, changed per phase by the stimulus process
  int send_idle_pct = 6;
  int recv_idle_pct = 67;
  int enq_pct       = 32;

  // long receiver stalls: stimulus bumps holds_asked, receiver serves it
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  int stuck_cycles;

  // Sequence numbers held in the window and how many of them went out,
  // tracked at issue time so replies can name the current head.
  logic [SEQ_W-1:0] held_seq[$];
  int               tx_done;

  always #5 clk = ~clk;

  go_back_n_send_window u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  gbn_window_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (in_if),
    .rsp_mon        (out_if),
    .mismatch_count (mismatch_count),
    .awaited        (awaited),
    .reqs_seen      (reqs_seen),
    .results_seen   (results_seen),
    .kinds_seen     (kinds_seen)
  );

  // One request transfer. Random sender gaps go in front of it; valid stays
  // high after the transfer so back-to-back requests need no extra step.
  task automatic offer(req_t r, logic [SEQ_W-1:0] s, logic [CHAN_W-1:0] c,
                       logic [LEN_W-1:0] l, logic [HND_W-1:0] h, logic a);
    case (r)
      REQ_ENQUEUE: if (held_seq.size() < WIN_DEPTH) held_seq.push_back(s);
      REQ_TX_SLOT: if (tx_done < held_seq.size()) tx_done++;
      REQ_REPLY: begin
        if (a && held_seq.size() > 0 && held_seq[0] == s) begin
          void'(held_seq.pop_front());
          if (tx_done > 0) tx_done--;
        end
      end
      default: if (held_seq.size() > 0) tx_done = 0;
    endcase
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= r;
    in_if.seq_number     <= s;
    in_if.channel_id     <= c;
    in_if.payload_length <= l;
    in_if.buffer_handle  <= h;
    in_if.reply_is_ack   <= a;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Mostly protocol-shaped traffic: replies usually ACK the real head so the
  // window keeps turning over; the rest is bad replies and raw noise.
  task automatic offer_mix();
    int               pick;
    req_t             r;
    logic [SEQ_W-1:0] s;
    logic             a;
    s    = $urandom;
    a    = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if ($urandom_range(99) < 6) begin
      r = req_t'($urandom_range(3));
    end else if (pick < enq_pct) begin
      r = REQ_ENQUEUE;
      if ($urandom_range(15) == 0) s = $urandom_range(1) ? '1 : '0;
    end else if (pick < enq_pct + 30) begin
      r = REQ_TX_SLOT;
    end else if (pick < 92) begin
      r = REQ_REPLY;
      if (held_seq.size() > 0) begin
        case ($urandom_range(9))
          7:       begin s = held_seq[0]; a = 1'b0; end  // NAK for the head
          8:       begin s = held_seq[0] ^ (SEQ_W'(1) << $urandom_range(SEQ_W-1)); a = 1'b1; end
          9:       ;                                     // stray reply
          default: begin s = held_seq[0]; a = 1'b1; end
        endcase
      end
    end else begin
      r = REQ_TIMEOUT;
    end
    offer(r, s, CHAN_W'($urandom), LEN_W'($urandom), HND_W'($urandom), a);
  endtask

  // Sender pause: nothing offered until every result has drained.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Receiver side: random stalls, plus a long hold on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: quiet cycles on both channels.
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.req_type       = REQ_ENQUEUE;
    in_if.seq_number     = '0;
    in_if.channel_id     = '0;
    in_if.payload_length = '0;
    in_if.buffer_handle  = '0;
    in_if.reply_is_ack   = 1'b0;
    tx_done              = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: empty window, fill to the brim, every reply flavor ---
    offer(REQ_TX_SLOT, $urandom, 8'h00, 16'h0000, 8'h00, 1'b0);  // nothing pending
    offer(REQ_TIMEOUT, $urandom, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);  // timeout, empty
    offer(REQ_ENQUEUE, '0, '0, '0, '0, 1'b0);
    offer(REQ_ENQUEUE, '1, '1, '1, '1, 1'b1);
    repeat (6) offer(REQ_ENQUEUE, $urandom, CHAN_W'($urandom), LEN_W'($urandom),
                     HND_W'($urandom), 1'($urandom_range(1)));
    offer(REQ_ENQUEUE, $urandom, 8'h5A, 16'h1234, 8'hA5, 1'b0);  // window full
    offer(REQ_REPLY, held_seq[0] + 1, '0, '0, '0, 1'b1);         // wrong seq
    offer(REQ_REPLY, held_seq[0], '0, '0, '0, 1'b0);             // not an ACK
    offer(REQ_REPLY, held_seq[0], '0, '0, '0, 1'b1);             // retire, none sent
    offer(REQ_TX_SLOT, '0, '0, '0, '0, 1'b0);
    offer(REQ_TX_SLOT, '1, '1, '1, '1, 1'b1);
    offer(REQ_TIMEOUT, '0, '0, '0, '0, 1'b0);                    // rewind
    offer(REQ_TX_SLOT, '0, '0, '0, '0, 1'b0);
    while (held_seq.size() > 0) offer(REQ_REPLY, held_seq[0], '1, '1, '1, 1'b1);
    // every slot has been written by now, so an empty-window reply is safe
    offer(REQ_REPLY, $urandom, '0, '0, '0, 1'b1);
    drain();

    // --- random, sender mostly busy, receiver mostly stalled ---
    repeat (530) offer_mix();
    drain();

    // --- random, the other way round, leaner enqueue mix ---
    send_idle_pct = 67;
    recv_idle_pct = 6;
    enq_pct       = 22;
    repeat (530) offer_mix();
    drain();

    // --- random, no idling; opens with a long receiver hold so the window
    //     and the result register fill and the request side backs up ---
    send_idle_pct = 0;
    recv_idle_pct = 0;
    enq_pct       = 27;
    holds_asked++;
    repeat (540) offer_mix();
    drain();
    repeat (4) @(posedge clk);

    $display("Covered %0d requests and %0d results over three idle profiles and a long",
             reqs_seen, results_seen);
    $display("result stall; result kinds seen (kind 7 leftmost): %b", kinds_seen);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
